// ----- hdl/dvre_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dvre_pkg
// Shared widths, codes and types of the distance-vector route engine.
// ----------------------------------------------------------------------------
package dvre_pkg;

    localparam int SELF_W   = 4;
    localparam int COUNT_W  = 5;
    localparam int PEER_W   = 4;
    localparam int TARGET_W = 4;
    localparam int VALUE_W  = 16;
    localparam int DEST_W   = 4;
    localparam int HOPOUT_W = 5;
    localparam int CFG_W    = 32;
    localparam int PADDR_W  = 3;

    localparam logic CMD_LINK   = 1'b0;
    localparam logic CMD_VECTOR = 1'b1;

    localparam logic REG_SELF  = 1'b0;
    localparam logic REG_COUNT = 1'b1;

    typedef struct packed {
        logic init;
        logic step;
    } path_ctrl_t;

endpackage
`default_nettype wire

// ----- hdl/dvre_cost_mem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dvre_cost_mem
// Cost table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dvre_cost_mem #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8,
    parameter int DATA_W = 16
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ----- hdl/dvre_path_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dvre_path_unit
// Shared saturating add and compare; keeps the best cost and hop of a column.
// ----------------------------------------------------------------------------
module dvre_path_unit #(
    parameter int COST_WIDTH = 16,
    parameter int IDX_W      = 4,
    parameter int HOP_W      = 5,
    parameter int HOP_NONE   = 16
) (
    input  wire logic                  clk,
    input  wire dvre_pkg::path_ctrl_t  ctrl,
    input  wire logic [IDX_W-1:0]      k,
    input  wire logic [COST_WIDTH-1:0] link_cost,
    input  wire logic [COST_WIDTH-1:0] table_cost,
    output logic      [COST_WIDTH-1:0] best,
    output logic      [HOP_W-1:0]      hop
);

    localparam logic [COST_WIDTH-1:0] INF = '1;

    logic [COST_WIDTH:0]   sum;
    logic [COST_WIDTH-1:0] total;
    logic [COST_WIDTH-1:0] best_reg;
    logic [HOP_W-1:0]      hop_reg;

    assign sum   = {1'b0, link_cost} + {1'b0, table_cost};
    assign total = sum[COST_WIDTH] ? INF : sum[COST_WIDTH-1:0];

    always_ff @(posedge clk)
    begin
        if (ctrl.init)
        begin
            best_reg <= INF;
            hop_reg  <= HOP_W'(HOP_NONE);
        end
        else if (ctrl.step && (total < best_reg))
        begin
            best_reg <= total;
            hop_reg  <= HOP_W'(k);
        end
    end

    assign best = best_reg;
    assign hop  = hop_reg;

endmodule
`default_nettype wire

// ----- hdl/distance_vector_route_engine.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// distance_vector_route_engine
// Distance-vector route engine for one node: link and vector updates, then a
// Bellman-Ford recompute that reports one route per destination other than itself.
// ----------------------------------------------------------------------------
// A vector element without end flag updates the cost table and starts no
// recompute. A recompute with n nodes in use visits each destination in turn
// (one cost table read per node in use through the shared add/compare unit);
// each route is registered and shows in the cycle after its destination finishes.
// Routes are strobed for one cycle; the receiver cannot stall.
// Reset: a clearing sweep over all MAX_NODE_COUNT^2 entries fills the cost
// table, busy is high meanwhile; configuration writes are taken as usual.
module distance_vector_route_engine #(
    parameter int MAX_NODE_COUNT = 16,
    parameter int COST_WIDTH     = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [dvre_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [dvre_pkg::CFG_W-1:0]      pwdata,
    output logic      [dvre_pkg::CFG_W-1:0]      prdata,
    output logic                                 pready,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic                            command,
    input  wire logic [dvre_pkg::PEER_W-1:0]     peer,
    input  wire logic [dvre_pkg::TARGET_W-1:0]   target,
    input  wire logic [dvre_pkg::VALUE_W-1:0]    cost_value,
    input  wire logic                            vector_end,
    output logic                                 route_valid,
    output logic      [dvre_pkg::DEST_W-1:0]     route_dest,
    output logic      [dvre_pkg::HOPOUT_W-1:0]   route_hop,
    output logic      [dvre_pkg::VALUE_W-1:0]    route_cost,
    output logic                                 route_changed,
    output logic                                 any_changed,
    output logic                                 final_entry
);

    localparam int IDX_W  = $clog2(MAX_NODE_COUNT);
    localparam int HOP_W  = $clog2(MAX_NODE_COUNT + 1);
    localparam int ADDR_W = $clog2(MAX_NODE_COUNT * MAX_NODE_COUNT);
    localparam int DEPTH  = MAX_NODE_COUNT * MAX_NODE_COUNT;
    localparam int CMP_W  = (HOP_W > dvre_pkg::COUNT_W) ? HOP_W : dvre_pkg::COUNT_W;

    localparam logic [COST_WIDTH-1:0] INF   = '1;
    localparam logic [31:0]           INF32 = 32'((64'd1 << COST_WIDTH) - 64'd1);
    localparam logic [CMP_W-1:0]      MAX_C = CMP_W'(MAX_NODE_COUNT);
    localparam logic [IDX_W-1:0]      LAST_IDX = IDX_W'(MAX_NODE_COUNT - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DEST  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    // configuration
    logic [dvre_pkg::SELF_W-1:0]  self_reg;
    logic [dvre_pkg::COUNT_W-1:0] node_count_reg;
    logic                         cfg_wr;

    // control
    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0] d_reg, d_next;
    logic             p_valid_reg, p_valid_next;
    logic [IDX_W-1:0] p_k_reg;
    logic             any_reg, any_next;
    logic [COST_WIDTH-1:0] old_reg;
    logic [COST_WIDTH-1:0] link_reg [MAX_NODE_COUNT];

    // output registers
    logic                            route_valid_reg, route_valid_next;
    logic [dvre_pkg::DEST_W-1:0]     dest_reg;
    logic [dvre_pkg::HOPOUT_W-1:0]   hop_out_reg;
    logic [dvre_pkg::VALUE_W-1:0]    cost_out_reg;
    logic                            changed_reg;
    logic                            any_out_reg;
    logic                            final_reg;

    // derived
    logic [CMP_W-1:0]      cnt_c, n_c, me_c, d_c, pk_c;
    logic                  me_in, peer_ok, target_ok, accept;
    logic [31:0]           val32;
    logic [COST_WIDTH-1:0] val_sat;
    logic                  is_final, changed_now;
    logic                  link_wr;

    // memory and unit
    logic                  mem_wr_en, mem_rd_en;
    logic [ADDR_W-1:0]     mem_wr_addr, mem_rd_addr;
    logic [COST_WIDTH-1:0] mem_wr_data, mem_rd_data;
    dvre_pkg::path_ctrl_t  path_ctrl;
    logic [COST_WIDTH-1:0] path_best;
    logic [HOP_W-1:0]      path_hop;
    logic [31:0]           best32, hop32, dest32;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == dvre_pkg::REG_SELF) ? dvre_pkg::CFG_W'(self_reg)
                                                     : dvre_pkg::CFG_W'(node_count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            self_reg       <= '0;
            node_count_reg <= dvre_pkg::COUNT_W'(16);
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == dvre_pkg::REG_SELF)
            begin
                self_reg <= pwdata[dvre_pkg::SELF_W-1:0];
            end
            else
            begin
                node_count_reg <= pwdata[dvre_pkg::COUNT_W-1:0];
            end
        end
    end

    // ---------------- derived values ----------------
    assign cnt_c = CMP_W'(node_count_reg);
    assign n_c   = (cnt_c == '0) ? CMP_W'(1) : ((cnt_c > MAX_C) ? MAX_C : cnt_c);
    assign me_c  = CMP_W'(self_reg);
    assign d_c   = CMP_W'(d_reg);
    assign pk_c  = CMP_W'(p_k_reg);
    assign me_in = me_c < n_c;

    assign peer_ok   = CMP_W'(peer) < n_c;
    assign target_ok = CMP_W'(target) < n_c;
    assign accept    = start && !busy;

    assign val32   = 32'(cost_value);
    assign val_sat = (val32 > INF32) ? INF : val32[COST_WIDTH-1:0];

    assign is_final = (d_c == n_c - CMP_W'(1)) ||
                      ((d_c == n_c - CMP_W'(2)) && (me_c == n_c - CMP_W'(1)));
    assign changed_now = me_in && (old_reg != path_best);

    assign busy = (state_reg != S_IDLE);

    // ---------------- cost table ----------------
    always_comb
    begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = ADDR_W'(ADDR_W'(k_reg) * ADDR_W'(MAX_NODE_COUNT) + ADDR_W'(d_reg));
        mem_wr_data = (k_reg == d_reg) ? '0 : INF;
        case (state_reg)
            S_CLEAR:
            begin
                mem_wr_en = 1'b1;
            end
            S_IDLE:
            begin
                mem_wr_en   = accept && (command == dvre_pkg::CMD_VECTOR) &&
                              peer_ok && target_ok;
                mem_wr_addr = ADDR_W'(ADDR_W'(IDX_W'(peer)) * ADDR_W'(MAX_NODE_COUNT)
                                      + ADDR_W'(IDX_W'(target)));
                mem_wr_data = val_sat;
            end
            S_EMIT:
            begin
                mem_wr_en   = changed_now;
                mem_wr_addr = ADDR_W'(ADDR_W'(IDX_W'(self_reg)) * ADDR_W'(MAX_NODE_COUNT)
                                      + ADDR_W'(d_reg));
                mem_wr_data = path_best;
            end
            default:
            begin
                mem_wr_en = 1'b0;
            end
        endcase
    end

    assign mem_rd_en   = (state_reg == S_READ);
    assign mem_rd_addr = ADDR_W'(ADDR_W'(k_reg) * ADDR_W'(MAX_NODE_COUNT) + ADDR_W'(d_reg));

    dvre_cost_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (COST_WIDTH)
    ) u_cost_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // ---------------- shared path unit ----------------
    assign path_ctrl.init = (state_reg == S_DEST);
    assign path_ctrl.step = p_valid_reg && (pk_c != me_c) && (link_reg[p_k_reg] != INF);

    dvre_path_unit #(
        .COST_WIDTH (COST_WIDTH),
        .IDX_W      (IDX_W),
        .HOP_W      (HOP_W),
        .HOP_NONE   (MAX_NODE_COUNT)
    ) u_path_unit (
        .clk        (clk),
        .ctrl       (path_ctrl),
        .k          (p_k_reg),
        .link_cost  (link_reg[p_k_reg]),
        .table_cost (mem_rd_data),
        .best       (path_best),
        .hop        (path_hop)
    );

    // ---------------- link costs ----------------
    assign link_wr = accept && (command == dvre_pkg::CMD_LINK) && peer_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_NODE_COUNT; i++)
            begin
                link_reg[i] <= INF;
            end
        end
        else if (link_wr)
        begin
            link_reg[IDX_W'(peer)] <= val_sat;
        end
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next       = state_reg;
        k_next           = k_reg;
        d_next           = d_reg;
        any_next         = any_reg;
        p_valid_next     = 1'b0;
        route_valid_next = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                if (d_reg == LAST_IDX)
                begin
                    d_next = '0;
                    if (k_reg == LAST_IDX)
                    begin
                        k_next     = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    d_next = d_reg + IDX_W'(1);
                end
            end
            S_IDLE:
            begin
                if (accept && ((command == dvre_pkg::CMD_LINK) || vector_end))
                begin
                    d_next     = '0;
                    any_next   = 1'b0;
                    state_next = S_DEST;
                end
            end
            S_DEST:
            begin
                if (d_c == me_c)
                begin
                    if (d_c == n_c - CMP_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        d_next = d_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    k_next     = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                p_valid_next = 1'b1;
                if (CMP_W'(k_reg) == n_c - CMP_W'(1))
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    k_next = k_reg + IDX_W'(1);
                end
            end
            S_DRAIN:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                route_valid_next = 1'b1;
                any_next         = any_reg || changed_now;
                if (is_final)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    d_next     = d_reg + IDX_W'(1);
                    state_next = S_DEST;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            k_reg           <= '0;
            d_reg           <= '0;
            any_reg         <= 1'b0;
            p_valid_reg     <= 1'b0;
            route_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            k_reg           <= k_next;
            d_reg           <= d_next;
            any_reg         <= any_next;
            p_valid_reg     <= p_valid_next;
            route_valid_reg <= route_valid_next;
        end
    end

    // own-row entry of the column, seen while walking past self
    always_ff @(posedge clk)
    begin
        p_k_reg <= k_reg;
        if (p_valid_reg && (pk_c == me_c))
        begin
            old_reg <= mem_rd_data;
        end
    end

    // ---------------- route output ----------------
    assign best32 = 32'(path_best);
    assign hop32  = 32'(path_hop);
    assign dest32 = 32'(d_reg);

    always_ff @(posedge clk)
    begin
        if (state_reg == S_EMIT)
        begin
            dest_reg     <= dest32[dvre_pkg::DEST_W-1:0];
            hop_out_reg  <= hop32[dvre_pkg::HOPOUT_W-1:0];
            cost_out_reg <= best32[dvre_pkg::VALUE_W-1:0];
            changed_reg  <= changed_now;
            any_out_reg  <= is_final && (any_reg || changed_now);
            final_reg    <= is_final;
        end
    end

    assign route_valid   = route_valid_reg;
    assign route_dest    = dest_reg;
    assign route_hop     = hop_out_reg;
    assign route_cost    = cost_out_reg;
    assign route_changed = changed_reg;
    assign any_changed   = any_out_reg;
    assign final_entry   = final_reg;

    // ---------------- assertions ----------------
    a_any_on_final: assert property (@(posedge clk) disable iff (!rst_n)
        (route_valid && any_changed) |-> final_entry)
        else $error("broadcast flag on a non-final route");

    a_busy_after_route: assert property (@(posedge clk) disable iff (!rst_n)
        (route_valid && !final_entry) |=> busy)
        else $error("engine idle before run finished");

    a_idle_on_final: assert property (@(posedge clk) disable iff (!rst_n)
        (route_valid && final_entry) |-> !busy)
        else $error("engine busy after final route");

    a_no_route_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && $past(!busy) && $past(!start)) |-> !route_valid)
        else $error("route without a recompute");

endmodule
`default_nettype wire
